// File: rtl/core/pcc_pkg.sv
`default_nettype none

package pcc_pkg;

  // Sizes of the path store and of the fields.
  localparam int unsigned MAX_AGENTS = 16;
  localparam int unsigned AGENT_W    = 4;
  localparam int unsigned MAX_STEPS  = 64;
  localparam int unsigned STEP_W     = 6;
  localparam int unsigned LOC_W      = 16;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned CFG_W      = 5;
  localparam int unsigned PAIRS_W    = 7;
  localparam int unsigned ADDR_W     = AGENT_W + STEP_W;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 8;

  // Kinds of input word, carried on tuser.
  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_COUNT = 2'd2
  } mode_t;

  // Sequencer states of the pair walk.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PAIR_A = 6'b000010,
    S_PAIR_B = 6'b000100,
    S_READ   = 6'b001000,
    S_CMP    = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/path_conflict_counter.sv
`default_nettype none

// Path conflict counter.
// Input stream (s_*): tuser carries the word kind (load, clear, count), tlast marks
// the last step of a path and sets its length to step plus one. A load writes one
// location of one agent's path, a clear empties all paths, a count returns one
// word on the output stream (m_*) with the number of conflicting agent pairs.
// Load and clear words are taken while idle and can follow back to back.
// A count walks every pair (i, j) with i < j below agents_in_use (capped at 16),
// one path step at a time, a read state then a compare state, through one shared
// pair of store read ports and comparators. Each pair is examined up to its first
// conflict or the shorter path length. While a count runs, s_tready stays low.
// The result sits in an output register; while the receiver stalls, loads and
// clears are still taken, but a finished count waits for that register.
// Reset empties all paths and sets agents_in_use to 16; stored locations are
// undefined until loaded. cfg_we/cfg_wdata write agents_in_use, and the user must
// do so only while idle; the block itself does not enforce this.
module path_conflict_counter (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // agent [3:0], step [9:4], location [25:10], zero fill [31:26]
  input  wire logic [pcc_pkg::IN_DATA_W-1:0]       s_tdata,
  // mode [1:0]
  input  wire logic [pcc_pkg::MODE_W-1:0]          s_tuser,
  input  wire logic                                s_tlast,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // conflict_pairs [6:0], zero fill [7]
  output logic [pcc_pkg::OUT_DATA_W-1:0]           m_tdata,
  input  wire logic                                cfg_we,
  input  wire logic [pcc_pkg::CFG_W-1:0]           cfg_wdata
);

  pcc_pkg::state_t                       state;
  logic [pcc_pkg::CFG_W-1:0]             agents_in_use;
  logic [pcc_pkg::CFG_W-1:0]             agents_active;
  logic [pcc_pkg::LEN_W-1:0]             path_length [pcc_pkg::MAX_AGENTS];
  logic [pcc_pkg::LOC_W-1:0]             path_store [1 << pcc_pkg::ADDR_W];
  logic [pcc_pkg::AGENT_W:0]             idx_a;
  logic [pcc_pkg::AGENT_W:0]             idx_b;
  logic [pcc_pkg::LEN_W-1:0]             len_a;
  logic [pcc_pkg::LEN_W-1:0]             len_min;
  logic [pcc_pkg::LEN_W-1:0]             t;
  logic                                  hit;
  logic [pcc_pkg::PAIRS_W-1:0]           pairs;
  logic [pcc_pkg::LOC_W-1:0]             rd_a;
  logic [pcc_pkg::LOC_W-1:0]             rd_b;
  logic [pcc_pkg::LOC_W-1:0]             prev_a;
  logic [pcc_pkg::LOC_W-1:0]             prev_b;
  logic [pcc_pkg::ADDR_W-1:0]            addr_a;
  logic [pcc_pkg::ADDR_W-1:0]            addr_b;
  logic [pcc_pkg::ADDR_W-1:0]            wr_addr;
  logic [pcc_pkg::AGENT_W-1:0]           in_agent;
  logic [pcc_pkg::STEP_W-1:0]            in_step;
  logic [pcc_pkg::LOC_W-1:0]             in_location;
  logic                                  in_fire;
  logic                                  load_fire;
  logic                                  vertex_hit;
  logic                                  edge_hit;
  logic [pcc_pkg::LEN_W-1:0]             len_b;
  logic                                  out_load;

  // Unpack the input word.
  assign in_agent    = s_tdata[pcc_pkg::AGENT_W-1:0];
  assign in_step     = s_tdata[pcc_pkg::AGENT_W +: pcc_pkg::STEP_W];
  assign in_location = s_tdata[pcc_pkg::ADDR_W +: pcc_pkg::LOC_W];
  assign s_tready    = (state == pcc_pkg::S_IDLE);
  assign in_fire     = s_tvalid && s_tready;
  assign load_fire   = in_fire && (s_tuser == pcc_pkg::MODE_LOAD);
  assign wr_addr     = {in_agent, in_step};

  // Agents that take part in a count, capped at the store size.
  assign agents_active = (agents_in_use > pcc_pkg::CFG_W'(pcc_pkg::MAX_AGENTS))
                         ? pcc_pkg::CFG_W'(pcc_pkg::MAX_AGENTS) : agents_in_use;

  // Read addresses of the current step of both paths.
  assign addr_a = {idx_a[pcc_pkg::AGENT_W-1:0], t[pcc_pkg::STEP_W-1:0]};
  assign addr_b = {idx_b[pcc_pkg::AGENT_W-1:0], t[pcc_pkg::STEP_W-1:0]};
  assign len_b  = path_length[idx_b[pcc_pkg::AGENT_W-1:0]];

  // Shared comparators: same cell now, or swapped cells since the last step.
  assign vertex_hit = (rd_a == rd_b);
  assign edge_hit   = (t != '0) && (prev_a == rd_b) && (rd_a == prev_b);

  // A finished count moves into the output register once that register is free.
  assign out_load = (state == pcc_pkg::S_FIN) && (!m_tvalid || m_tready);

  // Path store with one write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (load_fire) begin
      path_store[wr_addr] <= in_location;
    end
    rd_a <= path_store[addr_a];
    rd_b <= path_store[addr_b];
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      agents_in_use <= pcc_pkg::CFG_W'(pcc_pkg::MAX_AGENTS);
    end else if (cfg_we) begin
      agents_in_use <= cfg_wdata;
    end
  end

  // Path lengths: set by a load with tlast, emptied by a clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < pcc_pkg::MAX_AGENTS; k++) begin
        path_length[k] <= '0;
      end
    end else if (in_fire && (s_tuser == pcc_pkg::MODE_CLEAR)) begin
      for (int k = 0; k < pcc_pkg::MAX_AGENTS; k++) begin
        path_length[k] <= '0;
      end
    end else if (load_fire && s_tlast) begin
      path_length[in_agent] <= pcc_pkg::LEN_W'(in_step) + pcc_pkg::LEN_W'(1);
    end
  end

  // Output register: filled by a finished count, emptied when the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
      m_tdata  <= pcc_pkg::OUT_DATA_W'(pairs);
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Sequencer that walks all pairs and, per pair, the common steps up to the first conflict.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcc_pkg::S_IDLE;
    end else begin
      unique case (state)
        pcc_pkg::S_IDLE: begin
          if (in_fire && (s_tuser == pcc_pkg::MODE_COUNT)) begin
            idx_a <= '0;
            idx_b <= (pcc_pkg::AGENT_W+1)'(1);
            pairs <= '0;
            state <= pcc_pkg::S_PAIR_A;
          end
        end
        pcc_pkg::S_PAIR_A: begin
          if (idx_b >= agents_active) begin
            // Row done: move to the next first agent.
            idx_a <= idx_a + (pcc_pkg::AGENT_W+1)'(1);
            idx_b <= idx_a + (pcc_pkg::AGENT_W+1)'(2);
            if ((idx_a + (pcc_pkg::AGENT_W+1)'(2)) >= agents_active) begin
              state <= pcc_pkg::S_FIN;
            end
          end else begin
            len_a <= path_length[idx_a[pcc_pkg::AGENT_W-1:0]];
            state <= pcc_pkg::S_PAIR_B;
          end
        end
        pcc_pkg::S_PAIR_B: begin
          len_min <= (len_a < len_b) ? len_a : len_b;
          t       <= '0;
          hit     <= 1'b0;
          state   <= pcc_pkg::S_READ;
        end
        pcc_pkg::S_READ: begin
          if (hit || (t >= len_min)) begin
            // Pair finished: tally it and go to the next second agent.
            pairs <= pairs + pcc_pkg::PAIRS_W'(hit);
            idx_b <= idx_b + (pcc_pkg::AGENT_W+1)'(1);
            state <= pcc_pkg::S_PAIR_A;
          end else begin
            state <= pcc_pkg::S_CMP;
          end
        end
        pcc_pkg::S_CMP: begin
          hit    <= vertex_hit || edge_hit;
          prev_a <= rd_a;
          prev_b <= rd_b;
          t      <= t + pcc_pkg::LEN_W'(1);
          state  <= pcc_pkg::S_READ;
        end
        pcc_pkg::S_FIN: begin
          if (out_load) begin
            state <= pcc_pkg::S_IDLE;
          end
        end
        default: begin
          state <= pcc_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
